[src/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants for the buffer cache tag block
// operation and status codes, sequencer states, defaults
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int DEF_ENTRIES = 32;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_DIRTY   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_COUNT    = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT_SCAN,
        S_VIC_SCAN,
        S_RANK_SCAN,
        S_RESULT
    } t_state;

endpackage

[src/lbc_if.sv]
// ----------------------------------------------------------------------------
// lbc_req_if / lbc_rsp_if: request and response channels
// valid/ready handshake carrying one item per transfer
// ----------------------------------------------------------------------------
interface lbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  device;
    logic [31:0] block;
    logic [4:0]  buffer_index;
    modport source (output valid, operation, device, block, buffer_index, input ready);
    modport sink   (input valid, operation, device, block, buffer_index, output ready);
endinterface

interface lbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  granted_index;
    logic        hit;
    logic        fill_needed;
    logic        writeback_needed;
    logic [7:0]  writeback_device;
    logic [31:0] writeback_block;
    modport source (output valid, status, granted_index, hit, fill_needed,
                    writeback_needed, writeback_device, writeback_block, input ready);
    modport sink   (input valid, status, granted_index, hit, fill_needed,
                    writeback_needed, writeback_device, writeback_block, output ready);
endinterface

[src/lru_block_buffer_cache.sv]
// ----------------------------------------------------------------------------
// lru_block_buffer_cache: tag store of a block buffer cache with lru order
// one entry per cycle is visited by a single compare unit under a sequencer
// ----------------------------------------------------------------------------
//  channel | dir | transfer when        | payload
//  req     | in  | valid & ready        | operation, device, block, buffer_index
//  rsp     | out | valid & ready        | status, granted_index, hit, fill, writeback
//
//  a get runs the hit scan and, on a miss, the victim scan; a release that
//  drops the count to zero runs the recency scan; other operations go from
//  idle straight to the result. each scan visits one entry per cycle and
//  closes after the last entry. the result is held while the rsp is stalled.
//  reset is synchronous, active low; state comes up as all entries free with
//  index ENTRIES-1 most recent. the request side is not ready until the
//  response of the previous item has been transferred.
module lru_block_buffer_cache import lbc_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lbc_req_if.sink   i_req,
    lbc_rsp_if.source o_rsp
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // tag, count and rank arrays (flip-flops, reset to known values)
    logic [7:0]    r_tdev  [ENTRIES];
    logic [31:0]   r_tblk  [ENTRIES];
    logic [7:0]    r_cnt   [ENTRIES];
    logic [IW-1:0] r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid, r_dirty;

    t_state r_state, n_state;
    logic [CW-1:0] r_ptr;
    logic [IW-1:0] r_ei;
    logic [IW-1:0] r_brank, r_best;
    logic          r_found;

    logic [7:0]  r_dev;
    logic [31:0] r_blk;

    logic [1:0]  r_status;
    logic [4:0]  r_gidx;
    logic        r_hit, r_fill, r_wb;
    logic [7:0]  r_wdev;
    logic [31:0] r_wblk;

    logic [IW-1:0] w_p;
    logic          w_idx_ok;
    logic [IW-1:0] w_ei;

    assign w_p      = r_ptr[IW-1:0];
    assign w_idx_ok = ({{(32-5){1'b0}}, i_req.buffer_index} < 32'(ENTRIES));
    assign w_ei     = IW'(i_req.buffer_index);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_RESULT);
    assign o_rsp.status           = r_status;
    assign o_rsp.granted_index    = r_gidx;
    assign o_rsp.hit              = r_hit;
    assign o_rsp.fill_needed      = r_fill;
    assign o_rsp.writeback_needed = r_wb;
    assign o_rsp.writeback_device = r_wdev;
    assign o_rsp.writeback_block  = r_wblk;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (t_op'(i_req.operation) == OP_GET) n_state = S_HIT_SCAN;
                    else if (t_op'(i_req.operation) == OP_RELEASE && w_idx_ok &&
                             r_cnt[w_ei] == 8'd1) n_state = S_RANK_SCAN;
                    else n_state = S_RESULT;
                end
            end
            S_HIT_SCAN: begin
                if (r_ptr == CW'(ENTRIES)) n_state = r_found ? S_RESULT : S_VIC_SCAN;
            end
            S_VIC_SCAN, S_RANK_SCAN: begin
                if (r_ptr == CW'(ENTRIES)) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_tdev[i] <= '0;
                r_tblk[i] <= '0;
                r_cnt[i]  <= '0;
                r_rank[i] <= IW'(i);
            end
            r_ptr <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_ptr <= '0;
                    r_found <= 1'b0;
                    r_dev <= i_req.device;
                    r_blk <= i_req.block;
                    r_ei <= w_ei;
                    // rank of the released entry, held for the recency scan
                    r_brank <= r_rank[w_ei];
                    r_status <= ST_OK;
                    r_gidx <= '0;
                    r_hit <= 1'b0;
                    r_fill <= 1'b0;
                    r_wb <= 1'b0;
                    r_wdev <= '0;
                    r_wblk <= '0;
                    if (i_req.valid && w_idx_ok) begin
                        if (t_op'(i_req.operation) == OP_DIRTY) r_dirty[w_ei] <= 1'b1;
                        if (t_op'(i_req.operation) == OP_RELEASE) begin
                            if (r_cnt[w_ei] == 8'd0) r_status <= ST_COUNT;
                            else r_cnt[w_ei] <= r_cnt[w_ei] - 8'd1;
                        end
                    end
                end
                S_HIT_SCAN: begin
                    if (r_ptr != CW'(ENTRIES)) begin
                        if (r_tdev[w_p] == r_dev && r_tblk[w_p] == r_blk &&
                            (!r_found || r_rank[w_p] > r_brank)) begin
                            r_found <= 1'b1;
                            r_best <= w_p;
                            r_brank <= r_rank[w_p];
                        end
                        r_ptr <= r_ptr + 1'b1;
                    end else if (r_found) begin
                        r_gidx <= 5'(r_best);
                        r_hit <= 1'b1;
                        if (r_cnt[r_best] == 8'hff) r_status <= ST_COUNT;
                        else begin
                            r_cnt[r_best] <= r_cnt[r_best] + 8'd1;
                            if (!r_valid[r_best]) begin
                                r_fill <= 1'b1;
                                r_valid[r_best] <= 1'b1;
                            end
                        end
                    end else begin
                        r_ptr <= '0;
                    end
                end
                S_VIC_SCAN: begin
                    if (r_ptr != CW'(ENTRIES)) begin
                        if (r_cnt[w_p] == 8'd0 && (!r_found || r_rank[w_p] < r_brank)) begin
                            r_found <= 1'b1;
                            r_best <= w_p;
                            r_brank <= r_rank[w_p];
                        end
                        r_ptr <= r_ptr + 1'b1;
                    end else if (!r_found) begin
                        r_status <= ST_NO_FREE;
                    end else begin
                        if (r_dirty[r_best]) begin
                            r_wb <= 1'b1;
                            r_wdev <= r_tdev[r_best];
                            r_wblk <= r_tblk[r_best];
                        end
                        r_tdev[r_best] <= r_dev;
                        r_tblk[r_best] <= r_blk;
                        r_cnt[r_best] <= 8'd1;
                        r_dirty[r_best] <= 1'b0;
                        r_valid[r_best] <= 1'b1;
                        r_gidx <= 5'(r_best);
                        r_fill <= 1'b1;
                    end
                end
                S_RANK_SCAN: begin
                    // one entry per cycle: released to top, ranks above shift down
                    if (r_ptr != CW'(ENTRIES)) begin
                        if (w_p == r_ei) r_rank[w_p] <= IW'(ENTRIES - 1);
                        else if (r_rank[w_p] > r_brank) r_rank[w_p] <= r_rank[w_p] - 1'b1;
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_RESULT: ;
                default: ;
            endcase
        end
    end

    // response handshake and result checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_rsp.valid) else $error("rsp valid while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && !o_rsp.ready) |=> $stable(r_status) && $stable(r_gidx))
        else $error("result changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (r_status != ST_RESERVED)) else $error("bad status");
endmodule
